[rtl/core/cnlv_pkg.sv]
// ----------------------------------------------------------------------------
// cnlv_pkg
// Shared types, constants and helpers for the card number Luhn checker.
// ----------------------------------------------------------------------------
package cnlv_pkg;

  localparam int unsigned ValueW       = 54;  // binary card number width
  localparam int unsigned NumDigits    = 17;  // decimal digits that fit in ValueW bits
  localparam int unsigned BitsPerStage = 6;   // double-dabble shifts per stage
  localparam int unsigned BcdStages    = ValueW / BitsPerStage;
  localparam int unsigned MaxDigits    = 16;  // longest number that may pass
  localparam int unsigned LenW         = 5;
  localparam int unsigned PartDigits   = 5;   // digits per partial Luhn sum
  localparam int unsigned NumParts     = (NumDigits + PartDigits - 1) / PartDigits;
  localparam int unsigned PartW        = 6;   // holds 5 * 9
  localparam int unsigned SumW         = 8;   // holds 17 * 9
  localparam int unsigned InTdataW     = ((ValueW + 7) / 8) * 8;
  localparam int unsigned OutTdataW    = 8;

  localparam logic [LenW-1:0] LenShort = LenW'(13);
  localparam logic [LenW-1:0] LenMid   = LenW'(15);
  localparam logic [LenW-1:0] LenLong  = LenW'(16);

  typedef logic [3:0]                digit_t;
  typedef digit_t [NumDigits-1:0]    bcd_t;
  typedef logic [ValueW-1:0]         value_t;
  typedef logic [PartW-1:0]          part_t;

  typedef enum logic [1:0] {
    VerdictInvalid    = 2'd0,
    VerdictAmex       = 2'd1,
    VerdictMastercard = 2'd2,
    VerdictVisa       = 2'd3
  } verdict_e;

  // double-dabble correction: add 3 to a digit of 5 or more before the shift
  function automatic digit_t dabble_adj(digit_t d);
    return (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
  endfunction

  // Luhn doubling: 2d, less 9 when it exceeds 9
  function automatic digit_t luhn_double(digit_t d);
    logic [4:0] dbl;
    dbl = {d, 1'b0};
    return (dbl > 5'd9) ? digit_t'(dbl - 5'd9) : dbl[3:0];
  endfunction

endpackage

[rtl/core/cnlv_bcd_stage.sv]
// ----------------------------------------------------------------------------
// cnlv_bcd_stage
// One registered binary-to-BCD stage: BitsPerStage shift-and-add-3 steps.
// ----------------------------------------------------------------------------
module cnlv_bcd_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cnlv_pkg::bcd_t   bcd_i,
  input  cnlv_pkg::value_t bin_i,
  output logic            valid_o,
  output cnlv_pkg::bcd_t   bcd_o,
  output cnlv_pkg::value_t bin_o
);

  logic             valid_q;
  cnlv_pkg::bcd_t   bcd_d, bcd_q;
  cnlv_pkg::value_t bin_d, bin_q;

  always_comb begin
    logic [cnlv_pkg::NumDigits*4-1:0] flat;
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < int'(cnlv_pkg::BitsPerStage); s++) begin
      for (int k = 0; k < int'(cnlv_pkg::NumDigits); k++) begin
        bcd_d[k] = cnlv_pkg::dabble_adj(bcd_d[k]);
      end
      flat  = {bcd_d[cnlv_pkg::NumDigits-1:0]};
      flat  = {flat[cnlv_pkg::NumDigits*4-2:0], bin_d[cnlv_pkg::ValueW-1]};
      bcd_d = cnlv_pkg::bcd_t'(flat);
      bin_d = {bin_d[cnlv_pkg::ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

[rtl/core/cnlv_eval.sv]
// ----------------------------------------------------------------------------
// cnlv_eval
// Digit count, brand prefix and Luhn sum over the decimal digits, three stages.
// ----------------------------------------------------------------------------
module cnlv_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cnlv_pkg::bcd_t     bcd_i,
  output logic [2:0]        vld_o,
  output cnlv_pkg::verdict_e verdict_o
);

  // stage 1: length, leading pair, Luhn-mapped digits
  logic [cnlv_pkg::LenW-1:0] len_d, len_q;
  cnlv_pkg::digit_t          hi_d, hi_q, lo_d, lo_q;
  cnlv_pkg::bcd_t            ldig_d, ldig_q;
  // stage 2: brand and partial sums
  cnlv_pkg::verdict_e        brand_d, brand_q;
  cnlv_pkg::part_t [cnlv_pkg::NumParts-1:0] part_d, part_q;
  // stage 3: final verdict
  cnlv_pkg::verdict_e        verdict_d, verdict_q;
  logic [2:0]                vld_q;

  always_comb begin
    len_d  = '0;
    hi_d   = '0;
    lo_d   = '0;
    for (int i = 0; i < int'(cnlv_pkg::NumDigits); i++) begin
      if (bcd_i[i] != 4'd0) begin
        len_d = cnlv_pkg::LenW'(i + 1);
        hi_d  = bcd_i[i];
        lo_d  = (i > 0) ? bcd_i[(i > 0) ? i - 1 : 0] : 4'd0;
      end
      ldig_d[i] = ((i % 2) == 1) ? cnlv_pkg::luhn_double(bcd_i[i]) : bcd_i[i];
    end
  end

  always_comb begin
    logic len_ok;
    len_ok = (len_q <= cnlv_pkg::LenW'(cnlv_pkg::MaxDigits)) &&
             ((len_q == cnlv_pkg::LenShort) || (len_q == cnlv_pkg::LenMid) ||
              (len_q == cnlv_pkg::LenLong));
    if (!len_ok) begin
      brand_d = cnlv_pkg::VerdictInvalid;
    end else if (hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7)) begin
      brand_d = cnlv_pkg::VerdictAmex;
    end else if (hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5) begin
      brand_d = cnlv_pkg::VerdictMastercard;
    end else if (hi_q == 4'd4) begin
      brand_d = cnlv_pkg::VerdictVisa;
    end else begin
      brand_d = cnlv_pkg::VerdictInvalid;
    end
    for (int p = 0; p < int'(cnlv_pkg::NumParts); p++) begin
      part_d[p] = '0;
      for (int k = 0; k < int'(cnlv_pkg::PartDigits); k++) begin
        if (p * int'(cnlv_pkg::PartDigits) + k < int'(cnlv_pkg::NumDigits)) begin
          part_d[p] = part_d[p] +
            cnlv_pkg::PartW'(ldig_q[p * int'(cnlv_pkg::PartDigits) + k]);
        end
      end
    end
  end

  always_comb begin
    logic [cnlv_pkg::SumW-1:0] sum;
    logic                      mult10;
    sum    = '0;
    mult10 = 1'b0;
    for (int p = 0; p < int'(cnlv_pkg::NumParts); p++) begin
      sum = sum + cnlv_pkg::SumW'(part_q[p]);
    end
    // multiple-of-ten test against every multiple that fits
    for (int m = 0; m * 10 < (1 << cnlv_pkg::SumW); m++) begin
      if (sum == cnlv_pkg::SumW'(m * 10)) begin
        mult10 = 1'b1;
      end
    end
    verdict_d = mult10 ? brand_q : cnlv_pkg::VerdictInvalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q     <= len_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      ldig_q    <= ldig_d;
      brand_q   <= brand_d;
      part_q    <= part_d;
      verdict_q <= verdict_d;
    end
  end

  assign vld_o     = vld_q;
  assign verdict_o = verdict_q;

endmodule

[rtl/core/card_number_luhn_validator.sv]
// ----------------------------------------------------------------------------
// card_number_luhn_validator
// Luhn mod-10 card number check with brand decode, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata bits (low to high)          | request
//  ---------+-----+-----------------------------------+-------------------------
//  s_axis   | in  | card_value[53:0], 2'b0 pad        | one card number
//  m_axis   | out | verdict[1:0], 6'b0 pad            | 0 inv,1 amex,2 mc,3 visa
//
//  The pipe has 9 binary-to-BCD stages (6 bits each) followed by 3
//  evaluation stages (length/prefix/digit map, brand/partial sums, final sum).
//  A new request may enter every cycle that the output is not stalled.
//  All stages advance together on one enable; when the output holds an untaken
//  result, the whole pipe freezes and s_axis_tready drops.
//  Reset clears only the stage valid bits; data registers are not reset.
//
module card_number_luhn_validator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cnlv_pkg::InTdataW-1:0]  s_axis_tdata,   // [53:0] card_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cnlv_pkg::OutTdataW-1:0] m_axis_tdata    // [1:0] verdict
);

  localparam int unsigned NumStages = cnlv_pkg::BcdStages + 3;

  logic                   pipe_en;
  logic                   stg_vld [cnlv_pkg::BcdStages+1];
  cnlv_pkg::bcd_t         stg_bcd [cnlv_pkg::BcdStages+1];
  cnlv_pkg::value_t       stg_bin [cnlv_pkg::BcdStages+1];
  logic [2:0]             eval_vld;
  cnlv_pkg::verdict_e     verdict;
  logic [NumStages-1:0]   vld_vec;

  // whole pipe moves unless the output result is stuck
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // pad bits above the card value are ignored
  assign stg_vld[0] = s_axis_tvalid;
  assign stg_bcd[0] = '0;
  assign stg_bin[0] = s_axis_tdata[cnlv_pkg::ValueW-1:0];

  for (genvar g = 0; g < int'(cnlv_pkg::BcdStages); g++) begin : g_bcd
    cnlv_bcd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (stg_vld[g]),
      .bcd_i   (stg_bcd[g]),
      .bin_i   (stg_bin[g]),
      .valid_o (stg_vld[g+1]),
      .bcd_o   (stg_bcd[g+1]),
      .bin_o   (stg_bin[g+1])
    );
    assign vld_vec[g] = stg_vld[g+1];
  end

  // the last stage's leftover binary is all zeros by then and is dropped
  cnlv_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .valid_i   (stg_vld[cnlv_pkg::BcdStages]),
    .bcd_i     (stg_bcd[cnlv_pkg::BcdStages]),
    .vld_o     (eval_vld),
    .verdict_o (verdict)
  );

  assign vld_vec[NumStages-1:cnlv_pkg::BcdStages] = eval_vld;

  assign m_axis_tvalid = eval_vld[2];
  assign m_axis_tdata  = {{(cnlv_pkg::OutTdataW-2){1'b0}}, verdict};

  // no request in flight is lost while the output is not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && m_axis_tready) |=>
      ($countones(vld_vec) >= $past($countones(vld_vec))))
    else $error("pipeline lost a request during a stall");

  // a frozen pipe keeps its occupancy and its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> ($stable(vld_vec) && $stable(m_axis_tdata)))
    else $error("pipeline moved while stalled");

  // a stalled output keeps its valid bit until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

endmodule
